// ===== rtl/evr_pkg.sv =====
// Shared types, widths, register indexes and sequencer tables for the
// Euler vertex rotation block. No dependencies.
`default_nettype none

package evr_pkg;

  localparam int COORD_WIDTH    = 32;
  localparam int ANGLE_WIDTH    = 16;
  localparam int TRIG_FRAC_BITS = 16;

  localparam int OCT_BITS   = ANGLE_WIDTH - 3;
  localparam int TRIG_W     = TRIG_FRAC_BITS + 2;
  localparam int CFG_DATA_W = (COORD_WIDTH > ANGLE_WIDTH) ? COORD_WIDTH : ANGLE_WIDTH;
  localparam int CFG_IDX_W  = 3;
  localparam int N_AXES     = 3;
  localparam int SEL_W      = 2;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_YAW      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROLL     = 3'd5;

  localparam logic [SEL_W-1:0] AXIS_PITCH = 2'd0;
  localparam logic [SEL_W-1:0] AXIS_YAW   = 2'd1;
  localparam logic [SEL_W-1:0] AXIS_ROLL  = 2'd2;

  // Fixed-point widths of the sine/cosine sequencer (Q30 values up to 1.0).
  localparam int Q_W     = 31;
  localparam int T_W     = 33;
  localparam int PROD_W  = T_W + Q_W;
  localparam int RECIP_W = 32;
  localparam int RSH_W   = 6;
  localparam int STEP_W  = 4;
  localparam int OP_W    = 3;

  localparam logic [Q_W-1:0] PI4_Q30 = Q_W'(843314857);
  localparam logic [Q_W-1:0] ONE_Q30 = Q_W'(1) << 30;

  localparam logic [OP_W-1:0] OP_X   = 3'd0;
  localparam logic [OP_W-1:0] OP_X2  = 3'd1;
  localparam logic [OP_W-1:0] OP_DIV = 3'd2;
  localparam logic [OP_W-1:0] OP_MD  = 3'd3;
  localparam logic [OP_W-1:0] OP_SIN = 3'd4;
  localparam logic [OP_W-1:0] OP_FIN = 3'd5;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    coord_t a;
    coord_t b;
    coord_t c;
    logic   sat;
  } evr_beat_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] cos_v;
    logic signed [TRIG_W-1:0] sin_v;
  } evr_trig_t;

  typedef struct packed {
    logic                   start;
    logic [SEL_W-1:0]       sel;
    logic [ANGLE_WIDTH-1:0] angle;
  } evr_trig_req_t;

  // Micro-program of the Taylor evaluation: sine chain, then cosine chain.
  function automatic logic [OP_W-1:0] step_op(input logic [STEP_W-1:0] s);
    case (s)
      4'd0:    step_op = OP_X;
      4'd1:    step_op = OP_X2;
      4'd2:    step_op = OP_DIV;
      4'd3:    step_op = OP_MD;
      4'd4:    step_op = OP_MD;
      4'd5:    step_op = OP_MD;
      4'd6:    step_op = OP_SIN;
      4'd7:    step_op = OP_DIV;
      4'd8:    step_op = OP_MD;
      4'd9:    step_op = OP_MD;
      4'd10:   step_op = OP_MD;
      4'd11:   step_op = OP_MD;
      default: step_op = OP_FIN;
    endcase
  endfunction

  // Each divisor d is replaced by ceil(2^s / d) and a right shift by s, with
  // s = 31 + ceil(log2(d)), which is exact for every 31-bit dividend.
  function automatic logic [RECIP_W-1:0] step_recip(input logic [STEP_W-1:0] s);
    case (s)
      4'd2:    step_recip = 32'd3817748708;
      4'd3:    step_recip = 32'd3272356036;
      4'd4:    step_recip = 32'd3435973837;
      4'd5:    step_recip = 32'd2863311531;
      4'd7:    step_recip = 32'd3054198967;
      4'd8:    step_recip = 32'd2454267027;
      4'd9:    step_recip = 32'd2290649225;
      4'd10:   step_recip = 32'd2863311531;
      4'd11:   step_recip = 32'd2147483648;
      default: step_recip = 32'd0;
    endcase
  endfunction

  function automatic logic [RSH_W-1:0] step_shift(input logic [STEP_W-1:0] s);
    case (s)
      4'd2:    step_shift = 6'd38;
      4'd3:    step_shift = 6'd37;
      4'd4:    step_shift = 6'd36;
      4'd5:    step_shift = 6'd34;
      4'd7:    step_shift = 6'd38;
      4'd8:    step_shift = 6'd37;
      4'd9:    step_shift = 6'd36;
      4'd10:   step_shift = 6'd35;
      4'd11:   step_shift = 6'd32;
      default: step_shift = 6'd32;
    endcase
  endfunction

endpackage

`default_nettype wire

// ===== rtl/evr_rot_cell.sv =====
// One plane-rotation cell of the vertex chain: subtract, multiply, round,
// re-center and clamp in three registered stages. Depends on evr_pkg.
`default_nettype none

module evr_rot_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  evr_pkg::evr_beat_t   up_beat,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output evr_pkg::evr_beat_t   dn_beat,
  input  evr_pkg::coord_t      ctr_a,
  input  evr_pkg::coord_t      ctr_b,
  input  evr_pkg::evr_trig_t   trig
);
  import evr_pkg::*;

  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = DW + TRIG_W;
  localparam int SW = PW + 1;
  localparam int RW = SW - TRIG_FRAC_BITS;
  localparam int NW = RW + 1;

  localparam logic signed [NW-1:0] C_MAX = {{(NW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [NW-1:0] C_MIN = ~C_MAX;
  localparam logic signed [SW-1:0] HALF  = SW'(1) << (TRIG_FRAC_BITS - 1);

  logic v1_r, v2_r, v3_r;
  logic adv1, adv2, adv3;

  logic signed [DW-1:0] da_r, db_r, da_nxt, db_nxt;
  coord_t               c1_r, c2_r;
  logic                 sat1_r, sat2_r;

  logic signed [TRIG_W-1:0] cs, sn;
  logic signed [PW-1:0] pac_r, pbs_r, pas_r, pbc_r;
  logic signed [PW-1:0] pac_nxt, pbs_nxt, pas_nxt, pbc_nxt;

  logic signed [SW-1:0] sum_a, sum_b;
  logic signed [RW-1:0] rnd_a, rnd_b;
  logic signed [NW-1:0] na, nb;
  logic                 hi_a, lo_a, hi_b, lo_b;
  evr_beat_t            out_r, out_nxt;

  assign adv3     = !v3_r || dn_ready;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign up_ready = adv1;
  assign dn_valid = v3_r;
  assign dn_beat  = out_r;

  assign cs = trig.cos_v;
  assign sn = trig.sin_v;

  assign da_nxt = DW'(up_beat.a) - DW'(ctr_a);
  assign db_nxt = DW'(up_beat.b) - DW'(ctr_b);

  assign pac_nxt = PW'(da_r) * PW'(cs);
  assign pbs_nxt = PW'(db_r) * PW'(sn);
  assign pas_nxt = PW'(da_r) * PW'(sn);
  assign pbc_nxt = PW'(db_r) * PW'(cs);

  assign sum_a = SW'(pac_r) - SW'(pbs_r) + HALF;
  assign sum_b = SW'(pas_r) + SW'(pbc_r) + HALF;
  assign rnd_a = sum_a[SW-1:TRIG_FRAC_BITS];
  assign rnd_b = sum_b[SW-1:TRIG_FRAC_BITS];
  assign na    = NW'(rnd_a) + NW'(ctr_a);
  assign nb    = NW'(rnd_b) + NW'(ctr_b);

  always_comb begin
    hi_a = na > C_MAX;
    lo_a = na < C_MIN;
    hi_b = nb > C_MAX;
    lo_b = nb < C_MIN;
    out_nxt.a = hi_a ? C_MAX[COORD_WIDTH-1:0] : (lo_a ? C_MIN[COORD_WIDTH-1:0] : na[COORD_WIDTH-1:0]);
    out_nxt.b = hi_b ? C_MAX[COORD_WIDTH-1:0] : (lo_b ? C_MIN[COORD_WIDTH-1:0] : nb[COORD_WIDTH-1:0]);
    out_nxt.c = c2_r;
    out_nxt.sat = sat2_r || hi_a || lo_a || hi_b || lo_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= up_valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      da_r   <= da_nxt;
      db_r   <= db_nxt;
      c1_r   <= up_beat.c;
      sat1_r <= up_beat.sat;
    end
    if (adv2) begin
      pac_r  <= pac_nxt;
      pbs_r  <= pbs_nxt;
      pas_r  <= pas_nxt;
      pbc_r  <= pbc_nxt;
      c2_r   <= c1_r;
      sat2_r <= sat1_r;
    end
    if (adv3) begin
      out_r <= out_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/evr_trig_gen.sv =====
// Sine/cosine sequencer and cache: one shared multiplier, reciprocal
// multiplication for the small constant divisors, octant folding. Depends on evr_pkg.
`default_nettype none

module evr_trig_gen (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  evr_pkg::evr_trig_req_t                    req,
  output logic                                      busy,
  output evr_pkg::evr_trig_t [evr_pkg::N_AXES-1:0]  cache
);
  import evr_pkg::*;

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_START = 3'd1;
  localparam logic [2:0] PH_USE   = 3'd2;
  localparam logic [2:0] PH_DIV   = 3'd3;
  localparam logic [2:0] PH_QUO   = 3'd4;

  localparam int SH = 30 - TRIG_FRAC_BITS;

  logic [2:0]             ph_r, ph_nxt;
  logic [STEP_W-1:0]      step_r, step_nxt;
  logic [ANGLE_WIDTH-1:0] ang_r, ang_nxt;
  logic [SEL_W-1:0]       sel_r, sel_nxt;
  logic [Q_W-1:0]         x_r, x_nxt, x2_r, x2_nxt, p_r, p_nxt, s_r, s_nxt;
  logic [PROD_W-1:0]      prod_r, prod_nxt;
  logic [Q_W-1:0]         dvd_r, dvd_nxt;
  evr_trig_t [N_AXES-1:0] cache_r, cache_nxt;

  logic [OP_W-1:0]    op;
  logic [RECIP_W-1:0] recip;
  logic [RSH_W-1:0]   rsh;
  logic [2:0]         oct;
  logic [OCT_BITS:0]  w_ext, w_fold;
  logic [T_W-1:0]     t_val, mul_a;
  logic [Q_W-1:0]     mul_b;
  logic [PROD_W-1:0]  prod_calc, rnd_sum;
  logic [Q_W-1:0]     rnd, x_hi;
  logic [Q_W-1:0]     quo;
  logic [Q_W-1:0]     s_sum, c_sum;
  logic signed [TRIG_W-1:0] s0, c0, s1, c1;
  evr_trig_t          fin;

  assign op    = step_op(step_r);
  assign recip = step_recip(step_r);
  assign rsh   = step_shift(step_r);
  assign oct   = ang_r[ANGLE_WIDTH-1 -: 3];

  assign w_ext  = {1'b0, ang_r[OCT_BITS-1:0]};
  assign w_fold = oct[0] ? ({1'b1, {OCT_BITS{1'b0}}} - w_ext) : w_ext;
  assign t_val  = {w_fold, {(T_W-OCT_BITS-1){1'b0}}};

  always_comb begin
    if (ph_r == PH_DIV) begin
      mul_a = T_W'(recip);
      mul_b = dvd_r;
    end else begin
      case (op)
        OP_X: begin
          mul_a = t_val;
          mul_b = PI4_Q30;
        end
        OP_X2: begin
          mul_a = T_W'(x_r);
          mul_b = x_r;
        end
        OP_MD: begin
          mul_a = T_W'(x2_r);
          mul_b = p_r;
        end
        default: begin
          mul_a = T_W'(x_r);
          mul_b = p_r;
        end
      endcase
    end
  end

  assign prod_calc = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign rnd_sum   = prod_r + (PROD_W'(1) << 29);
  assign rnd       = rnd_sum[30 +: Q_W];
  assign x_hi      = prod_r[32 +: Q_W];
  assign quo       = Q_W'(prod_r >> rsh);

  assign s_sum = s_r + (Q_W'(1) << (SH - 1));
  assign c_sum = p_r + (Q_W'(1) << (SH - 1));
  assign s0    = {1'b0, s_sum[SH +: TRIG_FRAC_BITS+1]};
  assign c0    = {1'b0, c_sum[SH +: TRIG_FRAC_BITS+1]};
  assign s1    = oct[0] ? c0 : s0;
  assign c1    = oct[0] ? s0 : c0;

  always_comb begin
    case (oct[2:1])
      2'd0: begin
        fin.sin_v = s1;
        fin.cos_v = c1;
      end
      2'd1: begin
        fin.sin_v = c1;
        fin.cos_v = -s1;
      end
      2'd2: begin
        fin.sin_v = -s1;
        fin.cos_v = -c1;
      end
      default: begin
        fin.sin_v = -c1;
        fin.cos_v = s1;
      end
    endcase
  end

  always_comb begin
    ph_nxt    = ph_r;
    step_nxt  = step_r;
    ang_nxt   = ang_r;
    sel_nxt   = sel_r;
    x_nxt     = x_r;
    x2_nxt    = x2_r;
    p_nxt     = p_r;
    s_nxt     = s_r;
    prod_nxt  = prod_r;
    dvd_nxt   = dvd_r;
    cache_nxt = cache_r;
    case (ph_r)
      PH_IDLE: begin
        if (req.start) begin
          ang_nxt  = req.angle;
          sel_nxt  = req.sel;
          step_nxt = '0;
          ph_nxt   = PH_START;
        end
      end
      PH_START: begin
        case (op)
          OP_DIV: begin
            dvd_nxt = x2_r;
            ph_nxt  = PH_DIV;
          end
          OP_FIN: begin
            cache_nxt[sel_r] = fin;
            ph_nxt           = PH_IDLE;
          end
          default: begin
            prod_nxt = prod_calc;
            ph_nxt   = PH_USE;
          end
        endcase
      end
      PH_USE: begin
        case (op)
          OP_X: begin
            x_nxt    = x_hi;
            step_nxt = step_r + STEP_W'(1);
            ph_nxt   = PH_START;
          end
          OP_X2: begin
            x2_nxt   = rnd;
            step_nxt = step_r + STEP_W'(1);
            ph_nxt   = PH_START;
          end
          OP_MD: begin
            dvd_nxt = rnd;
            ph_nxt  = PH_DIV;
          end
          default: begin
            s_nxt    = rnd;
            step_nxt = step_r + STEP_W'(1);
            ph_nxt   = PH_START;
          end
        endcase
      end
      PH_DIV: begin
        prod_nxt = prod_calc;
        ph_nxt   = PH_QUO;
      end
      PH_QUO: begin
        p_nxt    = ONE_Q30 - quo;
        step_nxt = step_r + STEP_W'(1);
        ph_nxt   = PH_START;
      end
      default: begin
        ph_nxt = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_IDLE;
      step_r <= '0;
      for (int i = 0; i < N_AXES; i++) begin
        cache_r[i].cos_v <= TRIG_W'(1) << TRIG_FRAC_BITS;
        cache_r[i].sin_v <= '0;
      end
    end else begin
      ph_r    <= ph_nxt;
      step_r  <= step_nxt;
      cache_r <= cache_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ang_r  <= ang_nxt;
    sel_r  <= sel_nxt;
    x_r    <= x_nxt;
    x2_r   <= x2_nxt;
    p_r    <= p_nxt;
    s_r    <= s_nxt;
    prod_r <= prod_nxt;
    dvd_r  <= dvd_nxt;
  end

  assign busy  = ph_r != PH_IDLE;
  assign cache = cache_r;

endmodule

`default_nettype wire

// ===== rtl/euler_vertex_rotate_about_point.sv =====
// Top level: configuration registers, sine/cosine sequencer and the chain
// of three rotation cells. Depends on evr_pkg, evr_trig_gen, evr_rot_cell.
`default_nettype none

// Rotates each Q16.16 vertex about the configured center: pitch (x-z),
// then yaw (x-y), then roll (y-z). The three rotation cells form a chain
// of nine pipeline stages; one vertex is accepted per cycle while the
// sequencer is idle and no stall backs up the chain. The last cell's
// stage is the output register, and bubbles in the chain keep accepting
// while a result waits. Writing an angle register starts the sine/cosine
// sequencer, which runs through one shared multiplier, dividing by its
// small constants through reciprocal multiplication; during that time
// in_ready and cfg_ready are low. Center writes take effect at once.
module euler_vertex_rotate_about_point (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  evr_pkg::coord_t                    in_vertex_x,
  input  evr_pkg::coord_t                    in_vertex_y,
  input  evr_pkg::coord_t                    in_vertex_z,
  output logic                               out_valid,
  input  logic                               out_ready,
  output evr_pkg::coord_t                    out_rotated_x,
  output evr_pkg::coord_t                    out_rotated_y,
  output evr_pkg::coord_t                    out_rotated_z,
  output logic                               out_saturated,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [evr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [evr_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import evr_pkg::*;

  coord_t ctr_x_r, ctr_y_r, ctr_z_r;
  coord_t ctr_x_nxt, ctr_y_nxt, ctr_z_nxt;

  evr_trig_req_t          req;
  logic                   busy;
  evr_trig_t [N_AXES-1:0] cache;

  logic      v0, r0, v1, r1, v2, r2;
  evr_beat_t b0, o0, b1, o1, b2, o2;

  assign cfg_ready = !busy;

  always_comb begin
    req       = '0;
    ctr_x_nxt = ctr_x_r;
    ctr_y_nxt = ctr_y_r;
    ctr_z_nxt = ctr_z_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CENTER_X: ctr_x_nxt = cfg_data[COORD_WIDTH-1:0];
        REG_CENTER_Y: ctr_y_nxt = cfg_data[COORD_WIDTH-1:0];
        REG_CENTER_Z: ctr_z_nxt = cfg_data[COORD_WIDTH-1:0];
        REG_PITCH: begin
          req.start = 1'b1;
          req.sel   = AXIS_PITCH;
          req.angle = cfg_data[ANGLE_WIDTH-1:0];
        end
        REG_YAW: begin
          req.start = 1'b1;
          req.sel   = AXIS_YAW;
          req.angle = cfg_data[ANGLE_WIDTH-1:0];
        end
        REG_ROLL: begin
          req.start = 1'b1;
          req.sel   = AXIS_ROLL;
          req.angle = cfg_data[ANGLE_WIDTH-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctr_x_r <= '0;
      ctr_y_r <= '0;
      ctr_z_r <= '0;
    end else begin
      ctr_x_r <= ctr_x_nxt;
      ctr_y_r <= ctr_y_nxt;
      ctr_z_r <= ctr_z_nxt;
    end
  end

  evr_trig_gen u_trig (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .busy  (busy),
    .cache (cache)
  );

  assign v0       = in_valid && !busy;
  assign in_ready = r0 && !busy;

  always_comb begin
    b0.a   = in_vertex_x;
    b0.b   = in_vertex_z;
    b0.c   = in_vertex_y;
    b0.sat = 1'b0;
    b1.a   = o0.a;
    b1.b   = o0.c;
    b1.c   = o0.b;
    b1.sat = o0.sat;
    b2.a   = o1.b;
    b2.b   = o1.c;
    b2.c   = o1.a;
    b2.sat = o1.sat;
  end

  evr_rot_cell u_pitch (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (v0),
    .up_ready (r0),
    .up_beat  (b0),
    .dn_valid (v1),
    .dn_ready (r1),
    .dn_beat  (o0),
    .ctr_a    (ctr_x_r),
    .ctr_b    (ctr_z_r),
    .trig     (cache[AXIS_PITCH])
  );

  evr_rot_cell u_yaw (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (v1),
    .up_ready (r1),
    .up_beat  (b1),
    .dn_valid (v2),
    .dn_ready (r2),
    .dn_beat  (o1),
    .ctr_a    (ctr_x_r),
    .ctr_b    (ctr_y_r),
    .trig     (cache[AXIS_YAW])
  );

  evr_rot_cell u_roll (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (v2),
    .up_ready (r2),
    .up_beat  (b2),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .dn_beat  (o2),
    .ctr_a    (ctr_y_r),
    .ctr_b    (ctr_z_r),
    .trig     (cache[AXIS_ROLL])
  );

  assign out_rotated_x = o2.c;
  assign out_rotated_y = o2.a;
  assign out_rotated_z = o2.b;
  assign out_saturated = o2.sat;

endmodule

`default_nettype wire

// ===== sim/euler_vertex_rotate_about_point_tb.sv =====
// Self-checking testbench for euler_vertex_rotate_about_point: random and directed
// vertices under changing centers and angles, checked against an internal fixed-point
// predictor. Depends on evr_pkg and the block's RTL.
`timescale 1ns / 1ps

module euler_vertex_rotate_about_point_tb;
  import evr_pkg::*;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vertex_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   sat;
  } rotated_vertex_t;

  localparam cfg_idx_t REG_SPARE_A = 3'd6;
  localparam cfg_idx_t REG_SPARE_B = 3'd7;

  localparam coord_t VTX_MAX = {1'b0, {(COORD_WIDTH - 1){1'b1}}};
  localparam coord_t VTX_MIN = {1'b1, {(COORD_WIDTH - 1){1'b0}}};
  localparam longint COORD_MAX = VTX_MAX;
  localparam longint COORD_MIN = VTX_MIN;
  localparam longint TRIG_ONE = longint'(1) <<< TRIG_FRAC_BITS;
  localparam longint HALF_LSB = longint'(1) <<< (TRIG_FRAC_BITS - 1);
  localparam int TRIG_SHIFT = 30 - TRIG_FRAC_BITS;
  localparam longint unsigned Q30_UNIT = 64'd1 << 30;
  localparam longint unsigned PI_QUARTER_Q30 = 64'd843314857;
  localparam int SMALL_SPAN = 1 << 22;
  localparam int PHASES = 10;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int CALM_PHASE = 3;
  localparam int PRESSURE_PHASE = 6;
  localparam int HOLD_CYCLES = 200;
  localparam int TAIL_CYCLES = 20;
  localparam int TIMEOUT_NS = 5_000_000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  coord_t in_vertex_x = '0;
  coord_t in_vertex_y = '0;
  coord_t in_vertex_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  coord_t out_rotated_x;
  coord_t out_rotated_y;
  coord_t out_rotated_z;
  logic out_saturated;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  cfg_idx_t cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  longint ctr_x, ctr_y, ctr_z;
  longint trig_cos [N_AXES];
  longint trig_sin [N_AXES];

  vertex_t vertices_to_send[$];
  rotated_vertex_t rotations_due[$];
  vertex_t next_vertex;
  rotated_vertex_t due;

  int in_gap_pct = 35;
  int out_gap_pct = 35;
  logic hold_armed = 1'b0;
  logic hold_done = 1'b0;
  int hold_left = 0;

  int items_queued = 0;
  int results_checked = 0;
  int mismatches = 0;
  int saturated_seen = 0;
  int reg_writes = 0;
  int settings_used = 1;

  logic [ANGLE_WIDTH-1:0] key_angles [12] = '{
    16'h0000, 16'h0001, 16'h1FFF, 16'h2000, 16'h4000, 16'h6000,
    16'h8000, 16'hA000, 16'hC000, 16'hE000, 16'hFFFF, 16'h5555
  };

  euler_vertex_rotate_about_point dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_vertex_x   (in_vertex_x),
    .in_vertex_y   (in_vertex_y),
    .in_vertex_z   (in_vertex_z),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_rotated_x (out_rotated_x),
    .out_rotated_y (out_rotated_y),
    .out_rotated_z (out_rotated_z),
    .out_saturated (out_saturated),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  function automatic longint unsigned rnd30(input longint unsigned a,
                                            input longint unsigned b);
    return (a * b + (64'd1 << 29)) >> 30;
  endfunction

  function automatic longint unsigned taylor_step(input longint unsigned x2,
                                                  input longint unsigned acc,
                                                  input longint unsigned div);
    return Q30_UNIT - rnd30(x2, acc) / div;
  endfunction

  function automatic longint to_trig(input longint unsigned v);
    return longint'((v + (64'd1 << (TRIG_SHIFT - 1))) >> TRIG_SHIFT);
  endfunction

  function automatic void derive_trig(input logic [ANGLE_WIDTH-1:0] ang,
                                      output longint cs, output longint sn);
    logic [2:0] oct;
    longint unsigned w, x, x2, p, q;
    longint s0, c0, s1, c1;
    oct = ang[ANGLE_WIDTH-1 -: 3];
    w = ang[OCT_BITS-1:0];
    if (oct[0]) w = (64'd1 << OCT_BITS) - w;
    x = ((w << (32 - OCT_BITS)) * PI_QUARTER_Q30) >> 32;
    x2 = rnd30(x, x);
    p = Q30_UNIT - x2 / 72;
    p = taylor_step(x2, p, 42);
    p = taylor_step(x2, p, 20);
    p = taylor_step(x2, p, 6);
    s0 = to_trig(rnd30(x, p));
    q = Q30_UNIT - x2 / 90;
    q = taylor_step(x2, q, 56);
    q = taylor_step(x2, q, 30);
    q = taylor_step(x2, q, 12);
    q = taylor_step(x2, q, 2);
    c0 = to_trig(q);
    if (oct[0]) begin
      s1 = c0;
      c1 = s0;
    end else begin
      s1 = s0;
      c1 = c0;
    end
    case (oct[2:1])
      2'd0: begin
        sn = s1;
        cs = c1;
      end
      2'd1: begin
        sn = c1;
        cs = -s1;
      end
      2'd2: begin
        sn = -s1;
        cs = -c1;
      end
      default: begin
        sn = -c1;
        cs = s1;
      end
    endcase
  endfunction

  function automatic longint round_dot(input longint d1, input longint t1,
                                       input longint d2, input longint t2);
    return (d1 * t1 + d2 * t2 + HALF_LSB) >>> TRIG_FRAC_BITS;
  endfunction

  function automatic longint clip(input longint v);
    if (v > COORD_MAX) return COORD_MAX;
    if (v < COORD_MIN) return COORD_MIN;
    return v;
  endfunction

  function automatic void spin_pair(inout longint a, inout longint b,
                                    input longint ca, input longint cb,
                                    input longint cs, input longint sn,
                                    inout logic sat);
    longint na, nb;
    na = round_dot(a - ca, cs, b - cb, -sn) + ca;
    nb = round_dot(a - ca, sn, b - cb, cs) + cb;
    a = clip(na);
    b = clip(nb);
    sat = sat | (a != na) | (b != nb);
  endfunction

  function automatic rotated_vertex_t rotate_vertex(input coord_t vx, input coord_t vy,
                                                    input coord_t vz);
    rotated_vertex_t r;
    longint x, y, z;
    logic sat;
    x = vx;
    y = vy;
    z = vz;
    sat = 1'b0;
    spin_pair(x, z, ctr_x, ctr_z, trig_cos[AXIS_PITCH], trig_sin[AXIS_PITCH], sat);
    spin_pair(x, y, ctr_x, ctr_y, trig_cos[AXIS_YAW], trig_sin[AXIS_YAW], sat);
    spin_pair(y, z, ctr_y, ctr_z, trig_cos[AXIS_ROLL], trig_sin[AXIS_ROLL], sat);
    r.x = x[COORD_WIDTH-1:0];
    r.y = y[COORD_WIDTH-1:0];
    r.z = z[COORD_WIDTH-1:0];
    r.sat = sat;
    return r;
  endfunction

  function automatic void check_field(input string field, input longint want,
                                      input longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endfunction

  function automatic coord_t pick_coord();
    case ($urandom_range(9))
      0: pick_coord = VTX_MAX;
      1: pick_coord = VTX_MIN;
      2, 3, 4: pick_coord = $urandom;
      default: pick_coord = coord_t'($urandom_range(SMALL_SPAN)) - coord_t'(SMALL_SPAN / 2);
    endcase
  endfunction

  task automatic queue_vertex(input coord_t x, input coord_t y, input coord_t z);
    vertices_to_send.push_back('{x: x, y: y, z: z});
    items_queued++;
  endtask

  // Called right after a rising edge; leaves cfg_valid high so that writes can
  // follow back to back. The caller lowers it when the setting is complete.
  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    reg_writes++;
    case (idx)
      REG_CENTER_X: ctr_x = $signed(data[COORD_WIDTH-1:0]);
      REG_CENTER_Y: ctr_y = $signed(data[COORD_WIDTH-1:0]);
      REG_CENTER_Z: ctr_z = $signed(data[COORD_WIDTH-1:0]);
      REG_PITCH: derive_trig(data[ANGLE_WIDTH-1:0], trig_cos[AXIS_PITCH],
                             trig_sin[AXIS_PITCH]);
      REG_YAW: derive_trig(data[ANGLE_WIDTH-1:0], trig_cos[AXIS_YAW],
                           trig_sin[AXIS_YAW]);
      REG_ROLL: derive_trig(data[ANGLE_WIDTH-1:0], trig_cos[AXIS_ROLL],
                            trig_sin[AXIS_ROLL]);
      default: ;
    endcase
  endtask

  task automatic drain();
    while (results_checked < items_queued) @(posedge clk);
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Verification failed");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        rotations_due.push_back(rotate_vertex(in_vertex_x, in_vertex_y, in_vertex_z));
      end
      if (!in_valid || in_ready) begin
        if (vertices_to_send.size() != 0 && $urandom_range(99) >= in_gap_pct) begin
          next_vertex = vertices_to_send.pop_front();
          in_valid <= 1'b1;
          in_vertex_x <= next_vertex.x;
          in_vertex_y <= next_vertex.y;
          in_vertex_z <= next_vertex.z;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (rotations_due.size() == 0) begin
          $error("Result beat with no vertex outstanding");
          mismatches++;
        end else begin
          due = rotations_due.pop_front();
          check_field("rotated_x", due.x, out_rotated_x);
          check_field("rotated_y", due.y, out_rotated_y);
          check_field("rotated_z", due.z, out_rotated_z);
          check_field("saturated", due.sat, out_saturated);
          if (out_saturated) saturated_seen++;
          results_checked++;
        end
      end
      // A long hold-off lets the pipeline fill so that in_ready drops.
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (hold_armed && !hold_done && out_valid) begin
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= out_gap_pct);
      end
    end
  end

  initial begin
    int phase;
    int n;
    int r;
    logic [CFG_DATA_W-1:0] word;
    ctr_x = 0;
    ctr_y = 0;
    ctr_z = 0;
    for (r = 0; r < N_AXES; r++) begin
      trig_cos[r] = TRIG_ONE;
      trig_sin[r] = 0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    queue_vertex('0, '0, '0);
    queue_vertex(VTX_MAX, VTX_MIN, -1);
    queue_vertex(VTX_MIN, VTX_MAX, 1);
    queue_vertex(32'sh0001_0000, -32'sh0001_0000, 32'sh0000_8000);
    queue_vertex(VTX_MAX, VTX_MAX, VTX_MAX);
    queue_vertex(VTX_MIN, VTX_MIN, VTX_MIN);
    drain();

    write_reg(REG_CENTER_X, VTX_MAX);
    write_reg(REG_CENTER_Y, VTX_MIN);
    write_reg(REG_CENTER_Z, '0);
    write_reg(REG_PITCH, 32'hABCD_2000);
    write_reg(REG_YAW, 32'h5A5A_FFFF);
    write_reg(REG_ROLL, 32'h0000_8000);
    write_reg(REG_SPARE_A, 32'hFFFF_FFFF);
    write_reg(REG_SPARE_B, 32'h1234_5678);
    cfg_valid <= 1'b0;
    settings_used++;
    queue_vertex('0, '0, '0);
    queue_vertex(VTX_MAX, VTX_MIN, '0);
    queue_vertex(VTX_MIN, VTX_MAX, VTX_MAX);
    queue_vertex(VTX_MIN, VTX_MIN, VTX_MIN);
    queue_vertex(VTX_MAX, VTX_MAX, VTX_MAX);
    queue_vertex(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000);
    queue_vertex(-1, -1, -1);
    queue_vertex(VTX_MAX, '0, VTX_MIN);
    drain();

    write_reg(REG_CENTER_X, '0);
    write_reg(REG_CENTER_Y, '0);
    write_reg(REG_PITCH, 32'h0000_4000);
    write_reg(REG_YAW, 32'hFFFF_C000);
    write_reg(REG_ROLL, 32'h0000_6000);
    cfg_valid <= 1'b0;
    settings_used++;
    queue_vertex(32'sh0001_0000, '0, '0);
    queue_vertex('0, 32'sh0001_0000, '0);
    queue_vertex('0, '0, 32'sh0001_0000);
    queue_vertex(VTX_MAX, VTX_MIN, VTX_MAX);
    drain();

    for (phase = 0; phase < PHASES; phase++) begin
      for (r = 0; r <= REG_ROLL; r++) begin
        if ($urandom_range(1) == 1) begin
          if (cfg_idx_t'(r) <= REG_CENTER_Z) begin
            word = pick_coord();
          end else begin
            word = $urandom;
            if ($urandom_range(2) == 0) word[ANGLE_WIDTH-1:0] = key_angles[$urandom_range(11)];
          end
          write_reg(cfg_idx_t'(r), word);
        end
      end
      if ($urandom_range(4) == 0) begin
        write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, $urandom);
      end
      cfg_valid <= 1'b0;
      settings_used++;
      in_gap_pct = (phase == CALM_PHASE || phase == PRESSURE_PHASE) ? 0 : 35;
      out_gap_pct = (phase == CALM_PHASE) ? 0 : 35;
      hold_armed = (phase == PRESSURE_PHASE);
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        queue_vertex(pick_coord(), pick_coord(), pick_coord());
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (rotations_due.size() != 0) begin
      $error("%0d rotated vertices never came out", rotations_due.size());
      mismatches++;
    end
    $display("Checked %0d rotated vertices under %0d center/angle settings (%0d writes).",
             results_checked, settings_used, reg_writes);
    $display("%0d results were clamped; %0d mismatches.", saturated_seen, mismatches);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== euler_vertex_rotate_about_point.f =====
rtl/evr_pkg.sv
rtl/evr_rot_cell.sv
rtl/evr_trig_gen.sv
rtl/euler_vertex_rotate_about_point.sv
sim/euler_vertex_rotate_about_point_tb.sv
